FILE: rtl/ctsm_pkg.sv
// ----------------------------------------------------------------------------
// ctsm_pkg
// Shared types and constants of the CFL time step reduction block: request
// and status bundles of the bit-serial units, register indexes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsm_pkg;

    localparam int W_DATA     = 32;
    localparam int W_CFG_IDX  = 2;
    localparam int W_CFG_DATA = 24;
    localparam int W_GAMMA    = 24;
    localparam int W_COURANT  = 17;

    localparam logic [W_CFG_IDX-1:0] CFG_GAMMA   = 2'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_COURANT = 2'd1;

    localparam logic [W_GAMMA-1:0]   GAMMA_RST   = 24'd72818;
    localparam logic [W_COURANT-1:0] COURANT_RST = 17'd26214;
    localparam logic [W_DATA-1:0]    MAX32       = 32'hFFFF_FFFF;

    localparam logic [5:0] MUL_STEPS       = 6'd32;
    localparam logic [5:0] SQRT_STEPS      = 6'd32;
    localparam logic [6:0] DIV_STEPS_SHORT = 7'd32;
    localparam logic [6:0] DIV_STEPS_LONG  = 7'd64;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [32:0] rem_init;
        logic [63:0] num_lo;
        logic [32:0] divisor;
        logic [6:0]  iters;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic sat;
    } t_div_sts;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
    } t_sqrt_req;

endpackage

`default_nettype wire

FILE: rtl/ctsm_mul.sv
// ----------------------------------------------------------------------------
// ctsm_mul
// Bit-serial shift-add multiplier, 32 x 32 to 64 bits, one multiplier bit
// per cycle, product held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsm_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctsm_pkg::t_mul_req i_req,
    output logic               o_busy,
    output logic [63:0]        o_prod
);

    logic [5:0]  r_cnt;
    logic [63:0] r_acc;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [32:0] w_sum;

    assign w_sum  = {1'b0, r_acc[63:32]} + (r_b[0] ? {1'b0, r_a} : 33'd0);
    assign o_busy = (r_cnt != 6'd0);
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_req.start) begin
            r_cnt <= ctsm_pkg::MUL_STEPS;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= 64'd0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (o_busy) begin
            r_acc <= {w_sum, r_acc[31:1]};
            r_b   <= {1'b0, r_b[31:1]};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ctsm_div.sv
// ----------------------------------------------------------------------------
// ctsm_div
// Restoring divider, one quotient bit per cycle. The remainder starts from
// the high part of the dividend, the low part shifts in MSB first.
// Flags saturation when the quotient would not fit the step count.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctsm_pkg::t_div_req i_req,
    output ctsm_pkg::t_div_sts o_sts,
    output logic [63:0]        o_quot
);

    logic [6:0]  r_cnt;
    logic        r_sat;
    logic [32:0] r_rem;
    logic [63:0] r_num;
    logic [32:0] r_div;
    logic [63:0] r_q;
    logic [33:0] w_trial;
    logic [33:0] w_diff;
    logic        w_ge;

    assign w_trial    = {r_rem, r_num[63]};
    assign w_ge       = (w_trial >= {1'b0, r_div});
    assign w_diff     = w_trial - {1'b0, r_div};
    assign o_sts.busy = (r_cnt != 7'd0);
    assign o_sts.sat  = r_sat;
    assign o_quot     = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 7'd0;
        end else if (i_req.start) begin
            r_cnt <= i_req.iters;
        end else if (o_sts.busy) begin
            r_cnt <= r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sat <= (i_req.rem_init >= i_req.divisor);
            r_rem <= i_req.rem_init;
            r_num <= i_req.num_lo;
            r_div <= i_req.divisor;
            r_q   <= 64'd0;
        end else if (o_sts.busy) begin
            r_rem <= w_ge ? w_diff[32:0] : w_trial[32:0];
            r_num <= {r_num[62:0], 1'b0};
            r_q   <= {r_q[62:0], w_ge};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ctsm_sqrt.sv
// ----------------------------------------------------------------------------
// ctsm_sqrt
// Digit-by-digit integer square root of a 64-bit value, two radicand bits
// and one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsm_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ctsm_pkg::t_sqrt_req i_req,
    output logic                o_busy,
    output logic [31:0]         o_root
);

    logic [5:0]  r_cnt;
    logic [63:0] r_x;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] w_cur;
    logic [35:0] w_trial;
    logic [35:0] w_diff;
    logic        w_ge;

    assign w_cur   = {r_rem, r_x[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_cur >= w_trial);
    assign w_diff  = w_cur - w_trial;
    assign o_busy  = (r_cnt != 6'd0);
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_req.start) begin
            r_cnt <= ctsm_pkg::SQRT_STEPS;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= i_req.x;
            r_rem  <= 34'd0;
            r_root <= 32'd0;
        end else if (o_busy) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_rem  <= w_ge ? w_diff[33:0] : w_cur[33:0];
            r_root <= {r_root[30:0], w_ge};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cfl_time_step_min.sv
// ----------------------------------------------------------------------------
// cfl_time_step_min
// CFL time step reduction: per cell crossing time from sound and flow speed,
// running minimum, scaled time step on the last cell of a sweep.
// ----------------------------------------------------------------------------
// One cell item at a time. An ordinary cell runs a 32-step flow speed division
// beside a 32-step gamma*energy product, the 64-step sound speed squared
// division beside the 32-step cell length product, a 32-step square root and
// a 32-step crossing time division, all in bit-serial units doing one bit
// per cycle, before the block is ready for the next cell. The last cell adds
// a 32-step product with the courant factor, and its time step then waits in
// an output register while the next cell is taken.
// Configuration writes are always accepted and are meant for an idle block.
`default_nettype none

module cfl_time_step_min (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [31:0]                         i_density,
    input  logic signed [31:0]                  i_momentum,
    input  logic [31:0]                         i_internal_energy,
    input  logic [31:0]                         i_metric_factor,
    input  logic [31:0]                         i_cell_width,
    input  logic                                i_last_cell,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [31:0]                         o_time_step,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ctsm_pkg::W_CFG_IDX-1:0]      i_cfg_index,
    input  logic [ctsm_pkg::W_CFG_DATA-1:0]     i_cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_GO1   = 4'd1;
    localparam logic [3:0] ST_WAIT1 = 4'd2;
    localparam logic [3:0] ST_GO2   = 4'd3;
    localparam logic [3:0] ST_WAIT2 = 4'd4;
    localparam logic [3:0] ST_GO3   = 4'd5;
    localparam logic [3:0] ST_WAIT3 = 4'd6;
    localparam logic [3:0] ST_GO4   = 4'd7;
    localparam logic [3:0] ST_WAIT4 = 4'd8;
    localparam logic [3:0] ST_GO5   = 4'd9;
    localparam logic [3:0] ST_WAIT5 = 4'd10;

    logic [3:0]  r_state;
    logic [3:0]  n_state;
    logic [23:0] r_gamma;
    logic [16:0] r_courant;
    logic [31:0] r_min;
    logic        r_out_valid;
    logic [31:0] r_time_step;

    logic [31:0] r_rho;
    logic [31:0] r_mag;
    logic [31:0] r_eint;
    logic [31:0] r_metric;
    logic [31:0] r_width;
    logic        r_last;
    logic [31:0] r_u;
    logic [55:0] r_p;
    logic [63:0] r_cs2;
    logic [63:0] r_len;
    logic [31:0] r_cs;

    ctsm_pkg::t_mul_req  mul_req;
    ctsm_pkg::t_div_req  div_req;
    ctsm_pkg::t_div_sts  div_sts;
    ctsm_pkg::t_sqrt_req sqrt_req;
    logic                mul_busy;
    logic                sqrt_busy;
    logic [63:0]         mul_prod;
    logic [63:0]         div_quot;
    logic [31:0]         sqrt_root;

    logic [31:0] w_mom;
    logic [31:0] w_mag;
    logic [32:0] w_sum;
    logic [31:0] w_cell_dt;
    logic [31:0] w_step;
    logic        w_accept;
    logic        w_out_free;
    logic        w_out_load;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_time_step = r_time_step;
    assign o_cfg_ready = 1'b1;

    assign w_accept   = i_valid && o_ready;
    assign w_mom      = i_momentum;
    assign w_mag      = w_mom[31] ? (~w_mom + 32'd1) : w_mom;
    assign w_sum      = {1'b0, r_u} + {1'b0, r_cs};
    assign w_cell_dt  = div_sts.sat ? ctsm_pkg::MAX32 : div_quot[31:0];
    assign w_step     = (mul_prod[63:48] != 16'd0) ? ctsm_pkg::MAX32 : mul_prod[47:16];
    assign w_out_free = !r_out_valid || i_ready;
    assign w_out_load = (r_state == ST_WAIT5) && !mul_busy && w_out_free;

    // unit requests
    always_comb begin
        mul_req  = '0;
        div_req  = '0;
        sqrt_req = '0;
        sqrt_req.x = r_cs2;
        case (r_state)
            ST_GO1: begin
                mul_req.start    = 1'b1;
                mul_req.a        = r_eint;
                mul_req.b        = {8'd0, r_gamma};
                div_req.start    = 1'b1;
                div_req.rem_init = {17'd0, r_mag[31:16]};
                div_req.num_lo   = {r_mag[15:0], 48'd0};
                div_req.divisor  = {1'b0, r_rho};
                div_req.iters    = ctsm_pkg::DIV_STEPS_SHORT;
            end
            ST_GO2: begin
                mul_req.start    = 1'b1;
                mul_req.a        = r_metric;
                mul_req.b        = r_width;
                div_req.start    = 1'b1;
                div_req.rem_init = {25'd0, r_p[55:48]};
                div_req.num_lo   = {r_p[47:0], 16'd0};
                div_req.divisor  = {1'b0, r_rho};
                div_req.iters    = ctsm_pkg::DIV_STEPS_LONG;
            end
            ST_GO3: begin
                sqrt_req.start   = 1'b1;
            end
            ST_GO4: begin
                div_req.start    = 1'b1;
                div_req.rem_init = {1'b0, r_len[63:32]};
                div_req.num_lo   = {r_len[31:0], 32'd0};
                div_req.divisor  = w_sum;
                div_req.iters    = ctsm_pkg::DIV_STEPS_SHORT;
            end
            ST_GO5: begin
                mul_req.start    = 1'b1;
                mul_req.a        = r_min;
                mul_req.b        = {15'd0, r_courant};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_GO1;
            ST_GO1:   n_state = ST_WAIT1;
            ST_WAIT1: if (!mul_busy && !div_sts.busy) n_state = ST_GO2;
            ST_GO2:   n_state = ST_WAIT2;
            ST_WAIT2: if (!mul_busy && !div_sts.busy) n_state = ST_GO3;
            ST_GO3:   n_state = ST_WAIT3;
            ST_WAIT3: if (!sqrt_busy) n_state = ST_GO4;
            ST_GO4:   n_state = ST_WAIT4;
            ST_WAIT4: begin
                if (!div_sts.busy) n_state = r_last ? ST_GO5 : ST_IDLE;
            end
            ST_GO5:   n_state = ST_WAIT5;
            ST_WAIT5: if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gamma     <= ctsm_pkg::GAMMA_RST;
            r_courant   <= ctsm_pkg::COURANT_RST;
            r_min       <= ctsm_pkg::MAX32;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ctsm_pkg::CFG_GAMMA:   r_gamma   <= i_cfg_data;
                    ctsm_pkg::CFG_COURANT: r_courant <= i_cfg_data[16:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_WAIT4) && !div_sts.busy && (w_cell_dt < r_min)) begin
                r_min <= w_cell_dt;
            end
            if (w_out_load) begin
                r_min       <= ctsm_pkg::MAX32;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath holding registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rho    <= i_density;
            r_mag    <= w_mag;
            r_eint   <= i_internal_energy;
            r_metric <= i_metric_factor;
            r_width  <= i_cell_width;
            r_last   <= i_last_cell;
        end
        if ((r_state == ST_WAIT1) && !mul_busy && !div_sts.busy) begin
            r_u <= div_sts.sat ? ctsm_pkg::MAX32 : div_quot[31:0];
            r_p <= mul_prod[55:0];
        end
        if ((r_state == ST_WAIT2) && !mul_busy && !div_sts.busy) begin
            r_cs2 <= div_sts.sat ? {64{1'b1}} : div_quot;
            r_len <= mul_prod;
        end
        if ((r_state == ST_WAIT3) && !sqrt_busy) begin
            r_cs <= sqrt_root;
        end
        if (w_out_load) begin
            r_time_step <= w_step;
        end
    end

    ctsm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_busy  (mul_busy),
        .o_prod  (mul_prod)
    );

    ctsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    ctsm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!mul_busy && !div_sts.busy && !sqrt_busy))
        else $error("unit busy while block idle");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_req.start || div_req.start || sqrt_req.start) |->
        (!mul_busy && !div_sts.busy && !sqrt_busy))
        else $error("unit restarted while busy");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_WAIT5) && $past(r_last))
        else $error("result not caused by last cell");

    a_min_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_min == ctsm_pkg::MAX32) && (r_state == ST_IDLE))
        else $error("running minimum not cleared after result");

endmodule

`default_nettype wire
